[design/olid_pkg.sv]
// shared types and codes for the ordered list core
`default_nettype none

package olid_pkg;

  localparam int DATA_W = 32;
  localparam int REQ_W  = 3;
  localparam int POS_W  = 12;
  localparam int CNT_W  = 13;

  // request codes
  localparam logic [REQ_W-1:0] REQ_INS_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_INS_END   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_INS_AFTER = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DELETE    = 3'd3;
  localparam logic [REQ_W-1:0] REQ_READ      = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_BAD_POS   = 2'd3;

endpackage

`default_nettype wire

[design/olid_ram.sv]
// entry storage: one write port, one read port, registered read data
`default_nettype none

module olid_ram
  import olid_pkg::*;
#(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [AW-1:0]     raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write and read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[design/ordered_list_insert_delete_core.sv]
// ordered list core: insert, delete and read over a memory-held list
// Full, bad position and unknown requests see done in the cycle after accept;
// a read passes through the read state; an insert shifts the (count - slot)
// entries up, then writes the value; a delete scans all count entries. The shift
// or scan moves one entry per cycle via the one read and one write memory port.
// One request at a time; a new one may be taken in the cycle done is high.
// Synchronous reset clears the count and returns to idle; entries are not cleared.
`default_nettype none

module ordered_list_insert_delete_core
  import olid_pkg::*;
#(
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [REQ_W-1:0]         req_type,
  input  wire logic signed [DATA_W-1:0] value,
  input  wire logic [POS_W-1:0]         position,
  output logic                          done,
  output logic [1:0]                    status,
  output logic [CNT_W-1:0]              count,
  output logic signed [DATA_W-1:0]      read_value
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [1:0] {S_IDLE, S_UP, S_DEL, S_RD} state_t;

  state_t            state;
  logic [CW-1:0]     cnt;
  logic [AW-1:0]     slot;
  logic [CW-1:0]     left;
  logic [AW-1:0]     rd_idx;
  logic [CW-1:0]     scan_idx;
  logic              pend;
  logic [AW-1:0]     pend_addr;
  logic              found;
  logic [DATA_W-1:0] val;

  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [DATA_W-1:0] mem_wd;
  logic              mem_re;
  logic [AW-1:0]     mem_ra;
  logic [DATA_W-1:0] mem_rd;

  logic [XW-1:0]     pos_x;
  logic [XW-1:0]     cnt_x;
  logic              pos_ok;

  assign busy   = (state != S_IDLE);
  assign count  = CNT_W'(cnt);
  assign pos_x  = XW'(position);
  assign cnt_x  = XW'(cnt);
  assign pos_ok = (pos_x < cnt_x);

  olid_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_wa),
    .wdata (mem_wd),
    .re    (mem_re),
    .raddr (mem_ra),
    .rdata (mem_rd)
  );

  // memory port control for each phase
  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    mem_re = 1'b0;
    mem_ra = '0;
    unique case (state)
      S_IDLE: begin
        if (start && req_type == REQ_READ && pos_ok) begin
          mem_re = 1'b1;
          mem_ra = AW'(position);
        end
      end
      S_UP: begin
        if (pend) begin
          mem_we = 1'b1;
          mem_wa = pend_addr;
          mem_wd = mem_rd;
        end else if (left == '0) begin
          mem_we = 1'b1;
          mem_wa = slot;
          mem_wd = val;
        end
        if (left != '0) begin
          mem_re = 1'b1;
          mem_ra = rd_idx;
        end
      end
      S_DEL: begin
        if (pend && found) begin
          mem_we = 1'b1;
          mem_wa = pend_addr - AW'(1);
          mem_wd = mem_rd;
        end
        if (scan_idx != cnt) begin
          mem_re = 1'b1;
          mem_ra = AW'(scan_idx);
        end
      end
      S_RD: begin
      end
      default: begin
      end
    endcase
  end

  // request sequencer and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
      pend  <= 1'b0;
      found <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            val        <= value;
            read_value <= '0;
            case (req_type)
              REQ_INS_FRONT, REQ_INS_END, REQ_INS_AFTER: begin
                if (cnt == CW'(DEPTH)) begin
                  done   <= 1'b1;
                  status <= ST_FULL;
                end else if (req_type == REQ_INS_AFTER && !pos_ok) begin
                  done   <= 1'b1;
                  status <= ST_BAD_POS;
                end else begin
                  state  <= S_UP;
                  pend   <= 1'b0;
                  rd_idx <= AW'(cnt - CW'(1));
                  if (req_type == REQ_INS_FRONT) begin
                    slot <= '0;
                    left <= cnt;
                  end else if (req_type == REQ_INS_END) begin
                    slot <= AW'(cnt);
                    left <= '0;
                  end else begin
                    slot <= AW'(pos_x + XW'(1));
                    left <= CW'(cnt_x - pos_x - XW'(1));
                  end
                end
              end
              REQ_DELETE: begin
                state    <= S_DEL;
                scan_idx <= '0;
                pend     <= 1'b0;
                found    <= 1'b0;
              end
              REQ_READ: begin
                if (pos_ok) begin
                  state <= S_RD;
                end else begin
                  done   <= 1'b1;
                  status <= ST_BAD_POS;
                end
              end
              default: begin
                done   <= 1'b1;
                status <= ST_OK;
              end
            endcase
          end
        end
        // move entries up from the tail, then place the new value
        S_UP: begin
          if (left != '0) begin
            pend      <= 1'b1;
            pend_addr <= rd_idx + AW'(1);
            rd_idx    <= rd_idx - AW'(1);
            left      <= left - CW'(1);
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              cnt    <= cnt + CW'(1);
              done   <= 1'b1;
              status <= ST_OK;
              state  <= S_IDLE;
            end
          end
        end
        // scan for the value, then pull later entries down one place
        S_DEL: begin
          if (pend && !found && mem_rd == val) begin
            found <= 1'b1;
          end
          if (scan_idx != cnt) begin
            pend      <= 1'b1;
            pend_addr <= AW'(scan_idx);
            scan_idx  <= scan_idx + CW'(1);
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              done  <= 1'b1;
              state <= S_IDLE;
              if (found) begin
                cnt    <= cnt - CW'(1);
                status <= ST_OK;
              end else begin
                status <= ST_NOT_FOUND;
              end
            end
          end
        end
        S_RD: begin
          done       <= 1'b1;
          status     <= ST_OK;
          read_value <= mem_rd;
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_write_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (CW'(mem_wa) <= cnt))
    else $error("memory write beyond list tail");

  a_full_reject: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cnt == CW'(DEPTH) &&
     (req_type == REQ_INS_FRONT || req_type == REQ_INS_END ||
      req_type == REQ_INS_AFTER))
    |=> (done && status == ST_FULL))
    else $error("insert into full list not rejected");

  a_cnt_with_done: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && cnt != $past(cnt)) |-> done)
    else $error("count changed without a result");
`endif

endmodule

`default_nettype wire

[dv/ordered_list_insert_delete_checker.sv]
// result checker for the ordered list core: shadow list, expected results, comparison
`timescale 1ns / 1ps

module ordered_list_insert_delete_checker
  import olid_pkg::*;
#(
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic                     busy,
  input  wire logic [REQ_W-1:0]         req_type,
  input  wire logic signed [DATA_W-1:0] value,
  input  wire logic [POS_W-1:0]         position,
  input  wire logic                     done,
  input  wire logic [1:0]               status,
  input  wire logic [CNT_W-1:0]         count,
  input  wire logic signed [DATA_W-1:0] read_value,
  output int                            fail_count,
  output int                            open_results,
  output int                            list_length
);

  // keep the log short when the core is badly broken
  localparam int REPORT_LIMIT = 200;

  typedef struct packed {
    logic [1:0]               status;
    logic [CNT_W-1:0]         count;
    logic signed [DATA_W-1:0] read_value;
  } list_result_t;

  // shadow copy of the list held by the core
  logic signed [DATA_W-1:0] shadow_entries [DEPTH];
  int                       shadow_len;

  // results still owed by the core, oldest first
  list_result_t             owed_results [$];

  // apply one request to the shadow list and work out its result
  task automatic apply_request(input logic [REQ_W-1:0] req,
                               input logic signed [DATA_W-1:0] v,
                               input logic [POS_W-1:0] pos,
                               output list_result_t res);
    int slot;
    int hit;
    int i;
    res.status     = ST_OK;
    res.read_value = '0;
    case (req)
      REQ_INS_FRONT, REQ_INS_END, REQ_INS_AFTER: begin
        // a full list is reported ahead of a bad position
        if (shadow_len >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          slot = -1;
          if (req == REQ_INS_FRONT) begin
            slot = 0;
          end else if (req == REQ_INS_END) begin
            slot = shadow_len;
          end else if (int'(pos) >= shadow_len) begin
            res.status = ST_BAD_POS;
          end else begin
            slot = int'(pos) + 1;
          end
          if (slot >= 0) begin
            for (i = shadow_len; i > slot; i--) shadow_entries[i] = shadow_entries[i-1];
            shadow_entries[slot] = v;
            shadow_len++;
          end
        end
      end
      REQ_DELETE: begin
        // only the first matching entry goes
        hit = -1;
        for (i = 0; i < shadow_len; i++) begin
          if (hit < 0 && shadow_entries[i] == v) hit = i;
        end
        if (hit < 0) begin
          res.status = ST_NOT_FOUND;
        end else begin
          for (i = hit; i + 1 < shadow_len; i++) shadow_entries[i] = shadow_entries[i+1];
          shadow_len--;
        end
      end
      REQ_READ: begin
        if (int'(pos) < shadow_len) res.read_value = shadow_entries[pos];
        else res.status = ST_BAD_POS;
      end
      default: begin
        // unknown request codes leave the list alone
      end
    endcase
    res.count = CNT_W'(shadow_len);
  endtask

  task automatic report_mismatch(input string field, input longint want, input longint got);
    if (fail_count < REPORT_LIMIT)
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
    fail_count++;
  endtask

  // watch both channels on every rising clock edge
  always @(posedge clk) begin : watch
    list_result_t want;
    list_result_t next_res;
    if (rst) begin
      shadow_len = 0;
      owed_results.delete();
    end else begin
      // result transfer: compare with the oldest expectation
      if (done) begin
        if (owed_results.size() == 0) begin
          if (fail_count < REPORT_LIMIT)
            $error("result with nothing outstanding: status %0d count %0d read_value %0d",
                   status, count, read_value);
          fail_count++;
        end else begin
          want = owed_results.pop_front();
          if (status !== want.status) report_mismatch("status", want.status, status);
          if (count !== want.count) report_mismatch("count", want.count, count);
          if (read_value !== want.read_value)
            report_mismatch("read_value", longint'(want.read_value), longint'(read_value));
        end
      end
      // request transfer: predict and queue
      if (start && !busy) begin
        apply_request(req_type, value, position, next_res);
        owed_results.push_back(next_res);
      end
    end
    open_results <= owed_results.size();
    list_length  <= shadow_len;
  end

endmodule

[dv/ordered_list_insert_delete_core_test.sv]
// testbench top for the ordered list core: stimulus, clock, reset and verdict
`timescale 1ns / 1ps

module ordered_list_insert_delete_core_test;
  import olid_pkg::*;

  localparam int DEPTH        = 4096;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = DEPTH + 100;
  localparam int RANDOM_ITEMS = 118;

  // request codes the core does not define
  localparam logic [REQ_W-1:0] REQ_UNKNOWN_FIRST = 3'd5;
  localparam logic [REQ_W-1:0] REQ_UNKNOWN_LAST  = 3'd7;

  localparam logic signed [DATA_W-1:0] VAL_MIN  = 32'h8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX  = 32'h7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] VAL_ONES = 32'hFFFF_FFFF;
  localparam logic [POS_W-1:0]         POS_TOP  = 12'hFFF;

  logic                     clk      = 1'b0;
  logic                     rst      = 1'b1;
  logic                     start    = 1'b0;
  logic [REQ_W-1:0]         req_type = '0;
  logic signed [DATA_W-1:0] value    = '0;
  logic [POS_W-1:0]         position = '0;

  logic                     busy;
  logic                     done;
  logic [1:0]               status;
  logic [CNT_W-1:0]         count;
  logic signed [DATA_W-1:0] read_value;

  int fail_count;
  int open_results;
  int list_length;
  int cycle_count = 0;
  int item_seq    = 0;

  // small set of values so that deletes hit and duplicates occur
  logic signed [DATA_W-1:0] value_pool [8];

  ordered_list_insert_delete_core #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req_type   (req_type),
    .value      (value),
    .position   (position),
    .done       (done),
    .status     (status),
    .count      (count),
    .read_value (read_value)
  );

  ordered_list_insert_delete_checker #(
    .DEPTH(DEPTH)
  ) list_check (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .value        (value),
    .position     (position),
    .done         (done),
    .status       (status),
    .count        (count),
    .read_value   (read_value),
    .fail_count   (fail_count),
    .open_results (open_results),
    .list_length  (list_length)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // one request transfer; start stays high when the next one follows at once
  task automatic issue_request(input logic [REQ_W-1:0] req,
                               input logic signed [DATA_W-1:0] v,
                               input logic [POS_W-1:0] pos);
    int gap;
    // every third stretch of sixteen goes back to back
    if ((item_seq / 16) % 3 == 1) gap = 0;
    else gap = $urandom_range(0, 15);
    item_seq++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    req_type <= req;
    value    <= v;
    position <= pos;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // drop start and wait for every owed result
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (open_results != 0) @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    if ($urandom_range(0, 9) < 6) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  task automatic random_request();
    int               pick;
    logic [REQ_W-1:0] req;
    logic [POS_W-1:0] pos;
    pick = $urandom_range(0, 99);
    if (pick < 14) req = REQ_INS_FRONT;
    else if (pick < 28) req = REQ_INS_END;
    else if (pick < 44) req = REQ_INS_AFTER;
    else if (pick < 64) req = REQ_DELETE;
    else if (pick < 92) req = REQ_READ;
    else req = REQ_W'($urandom_range(REQ_UNKNOWN_FIRST, REQ_UNKNOWN_LAST));
    // long lists make every shift slow; steer toward deletes
    if (list_length > 48 && pick < 44 && $urandom_range(0, 1) == 1) req = REQ_DELETE;
    // mostly positions near the list, sometimes anywhere
    if ($urandom_range(0, 99) < 85) pos = POS_W'($urandom_range(0, list_length));
    else pos = POS_W'($urandom_range(0, 4095));
    issue_request(req, pick_value(), pos);
  endtask

  initial begin : stimulus
    logic [REQ_W-1:0] code;

    value_pool[0] = VAL_MIN;
    value_pool[1] = VAL_MAX;
    value_pool[2] = '0;
    value_pool[3] = VAL_ONES;
    for (int p = 4; p < 8; p++) value_pool[p] = $urandom;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // empty list: bad read, missing delete, bad insert position
    issue_request(REQ_READ, '0, '0);
    issue_request(REQ_DELETE, 32'sd5, '0);
    issue_request(REQ_INS_AFTER, 32'sd9, '0);
    // unknown request codes
    for (int c = REQ_UNKNOWN_FIRST; c <= REQ_UNKNOWN_LAST; c++) begin
      code = REQ_W'(c);
      issue_request(code, $urandom, POS_TOP);
    end
    // build a short list with the extreme values
    issue_request(REQ_INS_FRONT, VAL_MAX, '0);
    issue_request(REQ_INS_END, VAL_MIN, POS_TOP);
    issue_request(REQ_INS_FRONT, '0, '0);
    issue_request(REQ_INS_END, VAL_ONES, '0);
    issue_request(REQ_INS_AFTER, 32'sh1234_5678, 12'd0);
    // insert after the last entry, a duplicate value
    issue_request(REQ_INS_AFTER, VAL_MAX, 12'd4);
    // insert after a position at or past the count
    issue_request(REQ_INS_AFTER, 32'sd3, 12'd6);
    issue_request(REQ_INS_AFTER, 32'sd3, POS_TOP);
    // reads: first, last, one past the end, top position
    issue_request(REQ_READ, '0, 12'd0);
    issue_request(REQ_READ, '0, 12'd5);
    issue_request(REQ_READ, '0, 12'd6);
    issue_request(REQ_READ, VAL_ONES, POS_TOP);
    // deletes: first of two duplicates, missing, first entry, last entry
    issue_request(REQ_DELETE, VAL_MAX, '0);
    issue_request(REQ_DELETE, 32'sh55AA_33CC, '0);
    issue_request(REQ_DELETE, '0, '0);
    issue_request(REQ_DELETE, VAL_MAX, '0);
    issue_request(REQ_READ, '0, 12'd2);

    // random traffic on a short list
    repeat (RANDOM_ITEMS) random_request();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[ordered_list_insert_delete_core.f]
design/olid_pkg.sv
design/olid_ram.sv
design/ordered_list_insert_delete_core.sv
dv/ordered_list_insert_delete_checker.sv
dv/ordered_list_insert_delete_core_test.sv
